### design/rc4_stream_cipher_unit_defines.svh
// Assertion macros for the checker module.
`ifndef RC4_STREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RC4SC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rc4sc: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define RC4SC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rc4sc: next-cycle implication failed");

`endif

### design/rc4sc_pkg.sv
package rc4sc_pkg;

    localparam int DATA_W        = 8;
    localparam int IDX_W         = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int KEY_W         = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int KLEN_W        = 5;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KIDX_W        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B
    } state_t;

endpackage

### design/rc4_stream_cipher_unit.sv
// RC4 stream cipher, byte in, byte out; encryption and decryption are the same.
// Input channel s_*: s_tdata carries the data byte, s_tuser marks the first byte
// of a message, s_tlast marks the last byte. Output channel m_*: m_tdata carries
// the transformed byte, m_tlast repeats the input mark.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 key bytes 0-7,
// 1 key bytes 8-15, 2 key length); write only while the block is idle.
// The S-box lives in one 256x8 synchronous RAM with one write and one read per
// cycle; a byte needs S[i], S[j] reads, two swap writes and an S[t] read.
// A byte is taken with its S[i] read; then come the S[j] read, the first swap
// write with the S[t] read, and the second swap write, which registers the result.
// The RAM write port and the dependent read chain set the pace: the next item is
// taken in the cycle of the second swap write, once the output register is free.
// A byte marked first runs the key schedule first: 256 steps, each with two reads
// and two swap writes, before its own byte goes through the steps above.
// Reset clears indices, restores key length 1 and marks every S-box entry as
// identity through per-entry valid bits, so no clearing pass is needed.
// When m_tready is low the result holds in the output register, and the block
// stalls in its last step with s_tready low until the result is taken.
module rc4_stream_cipher_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rc4sc_pkg::DATA_W-1:0]       s_tdata,   // data_byte[7:0]
    input  logic                               s_tuser,   // first_byte
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rc4sc_pkg::DATA_W-1:0]       m_tdata,   // out_byte[7:0]
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rc4sc_pkg::*;

    logic [DATA_W-1:0] sbox_mem [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] valid_reg;

    state_t state_reg, state_next;
    logic ksa_reg, ksa_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] sa_reg, sa_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic last_reg, last_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic m_tlast_reg, m_tlast_next;
    logic [KEY_W-1:0] key_low_reg, key_high_reg;
    logic [KLEN_W-1:0] klen_reg;

    logic [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic rd_valid_reg;
    logic fwd_hit_reg, fwd_hit_next;
    logic [DATA_W-1:0] fwd_data_reg, fwd_data_next;

    logic mem_we, mem_re, valid_clear, in_accept, out_free;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] rval, key_byte;
    logic [2*KEY_W-1:0] key_all;
    logic [KLEN_W-1:0] klen_m1;
    logic [KIDX_W-1:0] kidx_last;
    logic [IDX_W-1:0] i_inc, j_sum, t_addr;

    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[{kidx_reg, 3'b000} +: DATA_W];
    assign klen_m1  = klen_reg - KLEN_W'(1);

    always_comb begin
        if (klen_reg == '0) begin
            kidx_last = '0;
        end else if (klen_reg > KLEN_W'(MAX_KEY_BYTES)) begin
            kidx_last = KIDX_W'(MAX_KEY_BYTES - 1);
        end else begin
            kidx_last = klen_m1[KIDX_W-1:0];
        end
    end

    assign rval = fwd_hit_reg ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : rd_addr_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) ||
                       ((state_reg == ST_WR_B) && !ksa_reg && out_free);
    assign in_accept = s_tvalid && s_tready;
    assign i_inc     = i_reg + IDX_W'(1);
    assign j_sum     = j_reg + rval + (ksa_reg ? key_byte : DATA_W'(0));
    assign t_addr    = sa_reg + rval;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next    = state_reg;
        ksa_next      = ksa_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        kidx_next     = kidx_reg;
        a_next        = a_reg;
        sa_next       = sa_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        mem_we        = 1'b0;
        mem_waddr     = j_reg;
        mem_wdata     = sa_reg;
        mem_re        = 1'b0;
        mem_raddr     = i_inc;
        fwd_hit_next  = 1'b0;
        fwd_data_next = sa_reg;
        valid_clear   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_RD_A: begin
                mem_re = 1'b1;
                if (ksa_reg) begin
                    mem_raddr = k_reg;
                    a_next    = k_reg;
                end else begin
                    mem_raddr = i_inc;
                    i_next    = i_inc;
                    a_next    = i_inc;
                end
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                sa_next    = rval;
                j_next     = j_sum;
                mem_re     = 1'b1;
                mem_raddr  = j_sum;
                state_next = ST_WR_A;
            end
            ST_WR_A: begin
                mem_we        = 1'b1;
                mem_waddr     = a_reg;
                mem_wdata     = rval;
                mem_re        = 1'b1;
                mem_raddr     = t_addr;
                fwd_hit_next  = (t_addr == j_reg) || (t_addr == a_reg);
                fwd_data_next = (t_addr == j_reg) ? sa_reg : rval;
                state_next    = ST_WR_B;
            end
            ST_WR_B: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = sa_reg;
                if (ksa_reg) begin
                    k_next    = k_reg + IDX_W'(1);
                    kidx_next = (kidx_reg == kidx_last) ? '0 : kidx_reg + KIDX_W'(1);
                    if (k_reg == IDX_W'(SBOX_DEPTH - 1)) begin
                        ksa_next = 1'b0;
                        j_next   = '0;
                    end
                    state_next = ST_RD_A;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = data_reg ^ rval;
                    m_tlast_next  = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_accept) begin
            data_next = s_tdata;
            last_next = s_tlast;
            if (s_tuser) begin
                valid_clear = 1'b1;
                ksa_next    = 1'b1;
                k_next      = '0;
                kidx_next   = '0;
                i_next      = '0;
                j_next      = '0;
                state_next  = ST_RD_A;
            end else begin
                mem_re        = 1'b1;
                mem_raddr     = i_inc;
                i_next        = i_inc;
                a_next        = i_inc;
                fwd_hit_next  = (state_reg == ST_WR_B) && (i_inc == j_reg);
                fwd_data_next = sa_reg;
                state_next    = ST_RD_B;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sbox_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg  <= sbox_mem[mem_raddr];
            rd_addr_reg  <= mem_raddr;
            rd_valid_reg <= valid_reg[mem_raddr];
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= fwd_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || valid_clear) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksa_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            kidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            klen_reg     <= KLEN_W'(1);
        end else begin
            ksa_reg      <= ksa_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            kidx_reg     <= kidx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_KEY_LOW:    key_low_reg  <= cfg_data;
                    REG_KEY_HIGH:   key_high_reg <= cfg_data;
                    REG_KEY_LENGTH: klen_reg     <= cfg_data[KLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        sa_reg      <= sa_next;
        data_reg    <= data_next;
        last_reg    <= last_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

### design/rc4sc_checker.sv
`include "rc4_stream_cipher_unit_defines.svh"

module rc4sc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rc4sc_pkg::DATA_W-1:0] m_tdata,
    input logic                         m_tlast
);
    import rc4sc_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;

    // hold a stalled result
    `RC4SC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // an item occupies the S-box port, so s_tready stays low while its reads and first swap write run
    `RC4SC_ASSERT_NEXT(a_no_accept_next, aclk, aresetn, in_acc, !s_tready)
    `RC4SC_ASSERT_IMPLY(a_no_accept_second, aclk, aresetn, in_acc, ##2 !s_tready)

endmodule

bind rc4_stream_cipher_unit rc4sc_checker u_rc4sc_checker (.*);

### bench/rc4_stream_cipher_unit_tb.sv
module rc4_stream_cipher_unit_tb;
    import rc4sc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [DATA_W-1:0]     data;
        logic                  first;
        logic                  last;
        logic                  typed;
        logic [DATA_W-1:0]     typed_byte;
    } stim_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              last_out;
    } cipher_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;   // data_byte[7:0]
    logic                  s_tuser;   // first_byte
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;   // out_byte[7:0]
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [DATA_W-1:0]   perm [0:SBOX_DEPTH-1];
    logic [IDX_W-1:0]    ptr_i;
    logic [IDX_W-1:0]    ptr_j;
    logic [KEY_W-1:0]    key_lo;
    logic [KEY_W-1:0]    key_hi;
    logic [KLEN_W-1:0]   key_len;

    stim_row_t      stim_table [$];
    cipher_result_t cipher_expected [$];
    cipher_result_t head;

    bit tx_held;
    bit no_idle;
    int items_sent;
    int schedules;
    int reg_writes;
    int results_checked;
    int mismatches;
    int cycle_count;

    rc4_stream_cipher_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    task rc4_schedule_key();
        int k;
        int kl;
        logic [IDX_W-1:0] jj;
        logic [DATA_W-1:0] tmp;
        logic [2*KEY_W-1:0] key;
        kl = (key_len == 0) ? 1 : ((key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len);
        key = {key_hi, key_lo};
        for (k = 0; k < SBOX_DEPTH; k++) perm[k] = k[DATA_W-1:0];
        jj = '0;
        for (k = 0; k < SBOX_DEPTH; k++) begin
            jj = jj + perm[k] + key[8*(k % kl) +: 8];
            tmp = perm[k];
            perm[k] = perm[jj];
            perm[jj] = tmp;
        end
        ptr_i = '0;
        ptr_j = '0;
    endtask

    task rc4_cipher_byte(input logic [DATA_W-1:0] d, input logic f,
                         output logic [DATA_W-1:0] o);
        logic [DATA_W-1:0] tmp;
        logic [IDX_W-1:0] t;
        if (f) rc4_schedule_key();
        ptr_i = ptr_i + 1'b1;
        ptr_j = ptr_j + perm[ptr_i];
        tmp = perm[ptr_i];
        perm[ptr_i] = perm[ptr_j];
        perm[ptr_j] = tmp;
        t = perm[ptr_i] + perm[ptr_j];
        o = d ^ perm[t];
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task add_item(input logic [DATA_W-1:0] d, input logic f, input logic l);
        stim_row_t r;
        r = '0;
        r.data = d;
        r.first = f;
        r.last = l;
        stim_table.push_back(r);
    endtask

    task add_checked(input logic [DATA_W-1:0] d, input logic f, input logic l,
                     input logic [DATA_W-1:0] e);
        stim_row_t r;
        r = '0;
        r.data = d;
        r.first = f;
        r.last = l;
        r.typed = 1'b1;
        r.typed_byte = e;
        stim_table.push_back(r);
    endtask

    task add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        stim_table.push_back(r);
    endtask

    task send_byte(input logic [DATA_W-1:0] d, input logic f, input logic l,
                   input logic typed, input logic [DATA_W-1:0] typed_byte);
        int gap;
        logic [DATA_W-1:0] predicted;
        cipher_result_t r;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            if (tx_held) s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= f;
        s_tlast <= l;
        tx_held = 1'b1;
        do @(posedge aclk); while (!s_tready);
        rc4_cipher_byte(d, f, predicted);
        r.out_byte = typed ? typed_byte : predicted;
        r.last_out = l;
        cipher_expected.push_back(r);
        items_sent++;
        if (f) schedules++;
    endtask

    // hold the sender until every outstanding item has produced its result
    task wait_drained();
        if (tx_held) begin
            s_tvalid <= 1'b0;
            tx_held = 1'b0;
        end
        while (cipher_expected.size() != 0) @(posedge aclk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_KEY_LOW:    key_lo = val;
            REG_KEY_HIGH:   key_hi = val;
            REG_KEY_LENGTH: key_len = val[KLEN_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task program_random_key();
        logic [CFG_DATA_W-1:0] len_word;
        logic [KLEN_W-1:0] len_pick;
        if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_LOW, {$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        case ($urandom_range(0, 9))
            0: len_pick = 5'd0;
            1: len_pick = 5'd1;
            2: len_pick = 5'd16;
            3: len_pick = KLEN_W'($urandom_range(17, 31));
            default: len_pick = KLEN_W'($urandom_range(1, 16));
        endcase
        len_word = {$urandom, $urandom};
        len_word[KLEN_W-1:0] = len_pick;
        write_reg(REG_KEY_LENGTH, len_word);
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task send_message(input int len, input bit close);
        int n;
        for (n = 0; n < len; n++)
            send_byte(DATA_W'($urandom_range(0, 255)), n == 0, close && (n == len - 1),
                      1'b0, '0);
    endtask

    initial begin
        int hold;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            hold = $urandom_range(1, 24);
            repeat (hold) @(posedge aclk);
            hold = no_idle ? 0 : pick_gap();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result byte %02h last %0b with no item outstanding",
                             m_tdata, m_tlast);
            end else begin
                head = cipher_expected.pop_front();
                results_checked++;
                if (m_tdata !== head.out_byte || m_tlast !== head.last_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on result %0d: expected %02h last %0b, got %02h last %0b",
                                 results_checked, head.out_byte, head.last_out,
                                 m_tdata, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int k;
        int directed_items;
        int msgs;
        int m;
        stim_row_t row;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_KEY_LOW;
        cfg_data <= '0;
        tx_held = 1'b0;
        no_idle = 1'b0;
        items_sent = 0;
        schedules = 0;
        reg_writes = 0;
        key_lo = '0;
        key_hi = '0;
        key_len = 5'd1;
        ptr_i = '0;
        ptr_j = '0;
        for (k = 0; k < SBOX_DEPTH; k++) perm[k] = k[DATA_W-1:0];

        // keystream straight from the identity S-box, no key schedule yet
        add_checked(8'h00, 1'b0, 1'b0, 8'h02);
        add_checked(8'hFF, 1'b0, 1'b0, 8'hFA);
        add_checked(8'hA5, 1'b0, 1'b1, 8'hA2);
        add_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(8'h3C, 1'b0, 1'b0);
        add_write(REG_KEY_LOW, 64'h0000_0000_0079_654B);
        add_write(REG_KEY_LENGTH, 64'd3);
        add_item(8'h50, 1'b1, 1'b0);
        add_item(8'h6C, 1'b0, 1'b0);
        add_item(8'h61, 1'b0, 1'b1);
        add_write(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(REG_KEY_LENGTH, 64'd0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h80, 1'b0, 1'b1);
        add_write(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        add_write(REG_KEY_LENGTH, 64'd31);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h01, 1'b0, 1'b0);
        // new key mid-message: old keystream continues until the next first byte
        add_write(REG_KEY_LOW, 64'h0);
        add_write(REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        add_item(8'h7E, 1'b0, 1'b0);
        add_item(8'h81, 1'b0, 1'b1);
        add_item(8'h55, 1'b1, 1'b1);
        add_write(REG_KEY_LENGTH, 64'd1);
        add_write(REG_KEY_LOW, 64'h0000_0000_0000_00FF);
        add_item(8'hAA, 1'b1, 1'b0);
        add_item(8'h0F, 1'b1, 1'b1);
        add_write(REG_KEY_LENGTH, 64'd17);
        add_item(8'hF0, 1'b1, 1'b1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < stim_table.size(); k++) begin
            row = stim_table[k];
            if (row.is_write) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_val);
                if (k + 1 == stim_table.size() || !stim_table[k + 1].is_write)
                    cfg_we <= 1'b0;
            end else begin
                send_byte(row.data, row.first, row.last, row.typed, row.typed_byte);
            end
        end
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    wait_drained();
                    program_random_key();
                end
                4: wait_drained();
                default: ;
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            // continue whatever message was left open, possibly under a new key
            if ($urandom_range(0, 3) == 0) begin
                msgs = $urandom_range(1, 5);
                for (m = 0; m < msgs; m++)
                    send_byte(DATA_W'($urandom_range(0, 255)), 1'b0,
                              (m == msgs - 1) && $urandom_range(0, 1), 1'b0, '0);
            end
            msgs = $urandom_range(1, 5);
            for (m = 0; m < msgs; m++) begin
                case ($urandom_range(0, 9))
                    0: send_byte(DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'b0, '0);
                    1: send_message($urandom_range(1, 12), 1'b0);
                    2: send_message($urandom_range(13, 48), 1'b1);
                    default: send_message($urandom_range(1, 12), 1'b1);
                endcase
            end
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d bytes (%0d directed), %0d key schedules, %0d register writes",
                 items_sent, directed_items, schedules, reg_writes);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
